### rtl/pat_pkg.sv
// shared types and constants for the perfect / amicable number tester
// used by pat_dp, pat_ctrl and perfect_amicable_test; no dependencies
`timescale 1ns / 1ps

package pat_pkg;

	// aliquot sums are carried and saturated at this width
	localparam int SUM_W = 40;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// result beat: verdict, first_sum, second_sum, padded to bytes
	localparam int OUT_FIELDS_W = 1 + 2 * SUM_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_START,
		S_DIV,
		S_EVAL,
		S_ACC,
		S_NEXT,
		S_FINISH
	} ctrl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;     // take a request beat
		logic setup;       // select operand, clear sum, divisor = 1
		logic start_div;   // launch one trial division
		logic eval;        // form addend from quotient/remainder, step divisor
		logic acc;         // saturating add of addend into the sum
		logic store;       // file the finished sum for the current operand
		logic load_out;    // load the result register
		logic sel_second;  // current operand is second_value
	} pat_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic n_small;      // selected operand below two
		logic div_done;     // trial division finished
		logic d_gt_q;       // divisor passed the square root
		logic op_amicable;  // request asks for the amicable test
		logic out_free;     // result register can take a beat
	} pat_status_t;

endpackage

### rtl/pat_div.sv
// restoring divider, one quotient bit per cycle
// standalone, no package use
`timescale 1ns / 1ps

module pat_div #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/pat_dp.sv
// datapath: operand registers, trial divisor, saturating sum, result register
// uses pat_pkg and instantiates pat_div
`timescale 1ns / 1ps

module pat_dp #(
	parameter int W          = 31,
	parameter int IN_TDATA_W = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pat_pkg::pat_cmd_t                cmd,
	output pat_pkg::pat_status_t             status,
	input  logic [IN_TDATA_W-1:0]            s_axis_tdata,
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	// wide enough for sums, operands and one addend without wrap
	localparam int SW = (((W + 1) > pat_pkg::SUM_W) ? (W + 1) : pat_pkg::SUM_W) + 1;

	logic                      op_q;
	logic [W-1:0]              a_q;
	logic [W-1:0]              b_q;
	logic [W-1:0]              n_q;
	logic [W-1:0]              d_q;
	logic [W:0]                addend_q;
	logic [pat_pkg::SUM_W-1:0] sum_q;
	logic                      sat_q;
	logic [pat_pkg::SUM_W-1:0] sa_q;
	logic [pat_pkg::SUM_W-1:0] sb_q;
	logic                      sat_a_q;
	logic                      sat_b_q;
	logic                      out_valid_q;
	logic [pat_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic         div_busy;
	logic         div_done;
	logic [W-1:0] quo;
	logic [W-1:0] rem;

	logic [W-1:0] n_sel;
	logic         cond_d;
	logic         cond_q;
	logic [W:0]   addend;
	logic [SW-1:0] acc_sum;
	logic [SW-1:0] sa_ext;
	logic [SW-1:0] sb_ext;
	logic [SW-1:0] a_ext;
	logic [SW-1:0] b_ext;
	logic          verdict;

	pat_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (n_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	assign n_sel = cmd.sel_second ? b_q : a_q;

	// divisor d and co-divisor q, each counted once and only when proper
	assign cond_d = (rem == '0) && (d_q < n_q);
	assign cond_q = (rem == '0) && (quo != d_q) && (quo < n_q);
	assign addend = (cond_d ? {1'b0, d_q} : '0) + (cond_q ? {1'b0, quo} : '0);

	assign acc_sum = {{(SW - pat_pkg::SUM_W){1'b0}}, sum_q} + {{(SW - W - 1){1'b0}}, addend_q};

	assign sa_ext = {{(SW - pat_pkg::SUM_W){1'b0}}, sa_q};
	assign sb_ext = {{(SW - pat_pkg::SUM_W){1'b0}}, sb_q};
	assign a_ext  = {{(SW - W){1'b0}}, a_q};
	assign b_ext  = {{(SW - W){1'b0}}, b_q};

	always_comb begin
		if (op_q) begin
			verdict = !sat_a_q && !sat_b_q && (a_q != b_q) && (sa_ext == b_ext)
				&& (sb_ext == a_ext);
		end else begin
			verdict = !sat_a_q && (a_q != '0) && (sa_ext == a_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= s_axis_tuser;
			a_q     <= s_axis_tdata[W-1:0];
			b_q     <= s_axis_tdata[2*W-1:W];
			sb_q    <= '0;
			sat_b_q <= 1'b0;
		end
		if (cmd.setup) begin
			n_q   <= n_sel;
			d_q   <= W'(1);
			sum_q <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.eval) begin
			addend_q <= addend;
			d_q      <= d_q + 1'b1;
		end
		if (cmd.acc) begin
			if (acc_sum > {{(SW - pat_pkg::SUM_W){1'b0}}, pat_pkg::SUM_MAX}) begin
				sum_q <= pat_pkg::SUM_MAX;
				sat_q <= 1'b1;
			end else begin
				sum_q <= acc_sum[pat_pkg::SUM_W-1:0];
			end
		end
		if (cmd.store) begin
			if (cmd.sel_second) begin
				sb_q    <= sum_q;
				sat_b_q <= sat_q;
			end else begin
				sa_q    <= sum_q;
				sat_a_q <= sat_q;
			end
		end
		if (cmd.load_out) begin
			out_data_q <= {{(pat_pkg::OUT_TDATA_W - pat_pkg::OUT_FIELDS_W){1'b0}},
				sb_q, sa_q, verdict};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.n_small     = (n_sel < W'(2));
	assign status.div_done    = div_done;
	assign status.d_gt_q      = (d_q > quo);
	assign status.op_amicable = op_q;
	assign status.out_free    = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_sat_pins_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc || cmd.store) && sat_q |-> sum_q == pat_pkg::SUM_MAX)
		else $error("saturated sum not at maximum");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> !div_busy)
		else $error("division launched while divider busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten before delivery");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> $past(div_busy))
		else $error("division done without a running division");
`endif

endmodule

### rtl/pat_ctrl.sv
// controller state machine sequencing operands, trial divisions and result load
// uses pat_pkg; drives the datapath through pat_cmd_t
`timescale 1ns / 1ps

module pat_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  pat_pkg::pat_status_t status,
	output pat_pkg::pat_cmd_t    cmd
);

	pat_pkg::ctrl_state_t state_q;
	pat_pkg::ctrl_state_t state_d;
	logic                 sel_second_q;
	logic                 accept;

	assign accept = s_axis_tvalid && (state_q == pat_pkg::S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pat_pkg::S_IDLE: begin
				if (s_axis_tvalid) state_d = pat_pkg::S_SETUP;
			end
			pat_pkg::S_SETUP: begin
				state_d = status.n_small ? pat_pkg::S_NEXT : pat_pkg::S_START;
			end
			pat_pkg::S_START: begin
				state_d = pat_pkg::S_DIV;
			end
			pat_pkg::S_DIV: begin
				if (status.div_done) state_d = pat_pkg::S_EVAL;
			end
			pat_pkg::S_EVAL: begin
				state_d = status.d_gt_q ? pat_pkg::S_NEXT : pat_pkg::S_ACC;
			end
			pat_pkg::S_ACC: begin
				state_d = pat_pkg::S_START;
			end
			pat_pkg::S_NEXT: begin
				if (!sel_second_q && status.op_amicable) begin
					state_d = pat_pkg::S_SETUP;
				end else begin
					state_d = pat_pkg::S_FINISH;
				end
			end
			pat_pkg::S_FINISH: begin
				if (status.out_free) state_d = pat_pkg::S_IDLE;
			end
			default: begin
				state_d = pat_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd            = '0;
		cmd.sel_second = sel_second_q;
		s_axis_tready  = 1'b0;
		case (state_q)
			pat_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.capture   = s_axis_tvalid;
			end
			pat_pkg::S_SETUP:  cmd.setup     = 1'b1;
			pat_pkg::S_START:  cmd.start_div = 1'b1;
			pat_pkg::S_EVAL:   cmd.eval      = !status.d_gt_q;
			pat_pkg::S_ACC:    cmd.acc       = 1'b1;
			pat_pkg::S_NEXT:   cmd.store     = 1'b1;
			pat_pkg::S_FINISH: cmd.load_out  = status.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pat_pkg::S_IDLE;
			sel_second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sel_second_q <= 1'b0;
			end else if (state_q == pat_pkg::S_NEXT && status.op_amicable) begin
				sel_second_q <= 1'b1;
			end
		end
	end

endmodule

### rtl/perfect_amicable_test.sv
// top level of the perfect / amicable number tester
// uses pat_pkg; instantiates pat_ctrl and pat_dp (which holds pat_div)
`timescale 1ns / 1ps

// Each request beat carries an operation in tuser (0 = is first_value perfect,
// 1 = are first_value and second_value amicable) and the operands in tdata.
// The block forms the aliquot sum (sum of proper divisors) of each operand by
// trial division up to the square root, pairing each divisor d with n/d, and
// returns one result beat: verdict, first_sum and second_sum (zero for the
// perfect test). Sums saturate at 2^40-1 and a saturated sum never matches.
// One is never perfect; an equal pair is never amicable; zero sums to zero.
// Timing: requests are handled one at a time. Each trial divisor goes through
// the shared restoring divider, one quotient bit per cycle; an operand n of
// two or more runs floor(sqrt(n))+1 candidate divisors after its setup step.
// An amicable request runs this loop for both operands. A new request is
// taken as soon as the previous result sits in the output register, even if
// it has not yet been taken.

module perfect_amicable_test #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// first_value, second_value, zero pad
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	// operation
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// verdict, first_sum, second_sum, zero pad
	output logic [pat_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int IN_TDATA_W = ((2 * VALUE_WIDTH + 7) / 8) * 8;

	pat_pkg::pat_cmd_t    cmd;
	pat_pkg::pat_status_t status;

	// sequencer: operand phase, divisor loop, result hand-off
	pat_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.status       (status),
		.cmd          (cmd)
	);

	// operands, divider, saturating accumulator and result register
	pat_dp #(
		.W         (VALUE_WIDTH),
		.IN_TDATA_W(IN_TDATA_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule
